// File: src/pls_pkg.sv
package pls_pkg;

   // storage geometry
   localparam int CAPACITY   = 128;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // word field widths
   localparam int KIND_W     = 4;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int LEN_W      = 8;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT     = KIND_W'(0),
      KIND_DELETE     = KIND_W'(1),
      KIND_READ       = KIND_W'(2),
      KIND_FIND       = KIND_W'(3),
      KIND_PUSH_FRONT = KIND_W'(4),
      KIND_PUSH_BACK  = KIND_W'(5),
      KIND_POP_FRONT  = KIND_W'(6),
      KIND_POP_BACK   = KIND_W'(7),
      KIND_CLEAR      = KIND_W'(8),
      KIND_SORT       = KIND_W'(9)
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = STATUS_W'(0),
      ST_BAD_POS   = STATUS_W'(1),
      ST_FULL      = STATUS_W'(2),
      ST_EMPTY     = STATUS_W'(3),
      ST_NOT_FOUND = STATUS_W'(4)
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT_UP,
      S_PUT_VAL,
      S_SHIFT_DOWN,
      S_CAPTURE,
      S_FIND,
      S_SORT_FIRST,
      S_SORT_WALK,
      S_SORT_END,
      S_FINISH
   } state_type;

   // read address source
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_LAST,
      RD_TGT,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   // write address source
   typedef enum logic [2:0] {
      WA_NEXT,
      WA_PREV,
      WA_TGT,
      WA_END,
      WA_LIM
   } wr_addr_type;

   // write data source
   typedef enum logic [1:0] {
      WD_READ,
      WD_VALUE,
      WD_MAX,
      WD_CARRY
   } wr_data_type;

   // element count update
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   // controller to datapath
   typedef struct packed {
      logic        latch_req;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_addr_type wr_addr;
      wr_data_type wr_data;
      cnt_op_type  cnt_op;
      logic        carry_load;
      logic        carry_min;
      logic        lim_load;
      logic        lim_dec;
      logic        set_status;
      status_type  status;
      logic        clear_result;
      logic        take_data;
      logic        take_found;
      logic        rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     pos_zero;
      logic     pos_over_cnt;
      logic     pos_over_next;
      logic     full;
      logic     empty;
      logic     cnt_le_one;
      logic     at_tgt;
      logic     at_last;
      logic     at_lim;
      logic     lim_is_one;
      logic     match;
   } stat_type;

endpackage

// File: src/pls_datapath.sv
module pls_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pls_pkg::cmd_type                      cmd,
   output pls_pkg::stat_type                     stat,
   input  logic [pls_pkg::KIND_W-1:0]            req_kind,
   input  logic [pls_pkg::POS_W-1:0]             req_position,
   input  logic signed [pls_pkg::DATA_WIDTH-1:0] req_value,
   output logic [pls_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [pls_pkg::DATA_WIDTH-1:0] rsp_data,
   output logic [pls_pkg::LEN_W-1:0]             rsp_found_at,
   output logic [pls_pkg::LEN_W-1:0]             rsp_length,
   output logic                                  rsp_is_empty
);
   import pls_pkg::*;

   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // latched request word
   logic [KIND_W-1:0]     kind_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [IDX_W-1:0]      tgt_ff, tgt_in;

   // list state and walk registers
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      src_ff;
   logic [IDX_W-1:0]      lim_ff;
   logic [DATA_WIDTH-1:0] carry_ff;
   logic [DATA_WIDTH-1:0] rd_ff;

   // working result and output word
   status_type            res_status_ff;
   logic [DATA_WIDTH-1:0] res_data_ff;
   logic [LEN_W-1:0]      res_found_ff;
   status_type            out_status_ff;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic [LEN_W-1:0]      out_found_ff;
   logic [LEN_W-1:0]      out_length_ff;
   logic                  out_empty_ff;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [IDX_W-1:0]      rd_addr, wr_addr, last_idx;
   logic [DATA_WIDTH-1:0] wr_word, max_word, min_word;
   logic                  carry_less;
   logic [CMP_W-1:0]      pos_x, cnt_x;

   // front operations work at index zero, the rest at position minus one
   always_comb begin
      if (kind_type'(req_kind) == KIND_PUSH_FRONT || kind_type'(req_kind) == KIND_POP_FRONT) begin
         tgt_in = '0;
      end else begin
         tgt_in = IDX_W'(req_position - POS_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff <= req_kind;
         pos_ff  <= req_position;
         val_ff  <= req_value;
         tgt_ff  <= tgt_in;
      end
   end

   // address and data selection
   assign last_idx = IDX_W'(cnt_ff - CNT_W'(1));

   always_comb begin
      unique case (cmd.rd_sel)
         RD_ZERO: rd_addr = '0;
         RD_LAST: rd_addr = last_idx;
         RD_TGT:  rd_addr = tgt_ff;
         RD_PREV: rd_addr = src_ff - IDX_W'(1);
         RD_NEXT: rd_addr = src_ff + IDX_W'(1);
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_addr)
         WA_NEXT: wr_addr = src_ff + IDX_W'(1);
         WA_PREV: wr_addr = src_ff - IDX_W'(1);
         WA_TGT:  wr_addr = tgt_ff;
         WA_END:  wr_addr = IDX_W'(cnt_ff);
         WA_LIM:  wr_addr = lim_ff;
         default: wr_addr = '0;
      endcase
   end

   assign carry_less = $signed(carry_ff) < $signed(rd_ff);
   assign max_word   = carry_less ? rd_ff : carry_ff;
   assign min_word   = carry_less ? carry_ff : rd_ff;

   always_comb begin
      unique case (cmd.wr_data)
         WD_READ:  wr_word = rd_ff;
         WD_VALUE: wr_word = val_ff;
         WD_MAX:   wr_word = max_word;
         WD_CARRY: wr_word = carry_ff;
         default:  wr_word = rd_ff;
      endcase
   end

   // element store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff  <= mem[rd_addr];
         src_ff <= rd_addr;
      end
   end

   // element count
   always_comb begin
      unique case (cmd.cnt_op)
         CNT_HOLD:  cnt_in = cnt_ff;
         CNT_INC:   cnt_in = cnt_ff + CNT_W'(1);
         CNT_DEC:   cnt_in = cnt_ff - CNT_W'(1);
         CNT_CLEAR: cnt_in = '0;
         default:   cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // sort pass bound and carried element
   always_ff @(posedge clock) begin
      if (cmd.lim_load) begin
         lim_ff <= last_idx;
      end else if (cmd.lim_dec) begin
         lim_ff <= lim_ff - IDX_W'(1);
      end
      if (cmd.carry_load) begin
         carry_ff <= rd_ff;
      end else if (cmd.carry_min) begin
         carry_ff <= min_word;
      end
   end

   // working result
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.clear_result) begin
         res_data_ff  <= '0;
         res_found_ff <= '0;
      end else begin
         if (cmd.take_data) begin
            res_data_ff <= rd_ff;
         end
         if (cmd.take_found) begin
            res_found_ff <= LEN_W'(src_ff) + LEN_W'(1);
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_data_ff   <= res_data_ff;
         out_found_ff  <= res_found_ff;
         out_length_ff <= LEN_W'(cnt_ff);
         out_empty_ff  <= (cnt_ff == '0);
      end
   end

   assign rsp_status   = out_status_ff;
   assign rsp_data     = out_data_ff;
   assign rsp_found_at = out_found_ff;
   assign rsp_length   = out_length_ff;
   assign rsp_is_empty = out_empty_ff;

   // status toward the controller
   assign pos_x = CMP_W'(pos_ff);
   assign cnt_x = CMP_W'(cnt_ff);

   always_comb begin
      stat.kind          = kind_type'(kind_ff);
      stat.pos_zero      = (pos_ff == '0);
      stat.pos_over_cnt  = (pos_x > cnt_x);
      stat.pos_over_next = (pos_x > cnt_x + CMP_W'(1));
      stat.full          = (cnt_ff == CNT_W'(CAPACITY));
      stat.empty         = (cnt_ff == '0);
      stat.cnt_le_one    = (cnt_ff <= CNT_W'(1));
      stat.at_tgt        = (src_ff == tgt_ff);
      stat.at_last       = (src_ff == last_idx);
      stat.at_lim        = (src_ff == lim_ff);
      stat.lim_is_one    = (lim_ff == IDX_W'(1));
      stat.match         = (rd_ff == val_ff);
   end

endmodule

// File: src/pls_ctrl.sv
module pls_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  pls_pkg::stat_type stat,
   output pls_pkg::cmd_type  cmd
);
   import pls_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and output word flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_sel   = RD_ZERO;
      cmd.wr_addr  = WA_END;
      cmd.wr_data  = WD_READ;
      cmd.cnt_op   = CNT_HOLD;
      cmd.status   = ST_OK;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECIDE;
            end
         end

         // check the request and start the walk it needs
         S_DECIDE: begin
            cmd.clear_result = 1'b1;
            cmd.set_status   = 1'b1;
            state_in         = S_FINISH;
            unique case (stat.kind)
               KIND_INSERT: begin
                  if (stat.pos_zero || stat.pos_over_next) begin
                     cmd.status = ST_BAD_POS;
                  end else if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else if (stat.pos_over_cnt) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = WA_END;
                     cmd.wr_data = WD_VALUE;
                     cmd.cnt_op  = CNT_INC;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = S_SHIFT_UP;
                  end
               end
               KIND_PUSH_FRONT: begin
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else if (stat.empty) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = WA_END;
                     cmd.wr_data = WD_VALUE;
                     cmd.cnt_op  = CNT_INC;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = S_SHIFT_UP;
                  end
               end
               KIND_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_addr = WA_END;
                     cmd.wr_data = WD_VALUE;
                     cmd.cnt_op  = CNT_INC;
                  end
               end
               KIND_DELETE, KIND_READ: begin
                  if (stat.empty) begin
                     cmd.status = ST_EMPTY;
                  end else if (stat.pos_zero || stat.pos_over_cnt) begin
                     cmd.status = ST_BAD_POS;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_TGT;
                     state_in   = (stat.kind == KIND_DELETE) ? S_SHIFT_DOWN : S_CAPTURE;
                  end
               end
               KIND_POP_FRONT: begin
                  if (stat.empty) begin
                     cmd.status = ST_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_TGT;
                     state_in   = S_SHIFT_DOWN;
                  end
               end
               KIND_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.status = ST_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_LAST;
                     state_in   = S_CAPTURE;
                  end
               end
               KIND_FIND: begin
                  cmd.status = ST_NOT_FOUND;
                  if (!stat.empty) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     state_in   = S_FIND;
                  end
               end
               KIND_CLEAR: begin
                  cmd.cnt_op = CNT_CLEAR;
               end
               KIND_SORT: begin
                  if (!stat.cnt_le_one) begin
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = RD_ZERO;
                     cmd.lim_load = 1'b1;
                     state_in     = S_SORT_FIRST;
                  end
               end
               default: begin
               end
            endcase
         end

         // move elements up one place, top first
         S_SHIFT_UP: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_NEXT;
            cmd.wr_data = WD_READ;
            if (stat.at_tgt) begin
               state_in = S_PUT_VAL;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
            end
         end

         S_PUT_VAL: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_TGT;
            cmd.wr_data = WD_VALUE;
            cmd.cnt_op  = CNT_INC;
            state_in    = S_FINISH;
         end

         // take the removed element, then close the gap
         S_SHIFT_DOWN: begin
            if (stat.at_tgt) begin
               cmd.take_data = 1'b1;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = WA_PREV;
               cmd.wr_data = WD_READ;
            end
            if (stat.at_last) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end

         S_CAPTURE: begin
            cmd.take_data = 1'b1;
            if (stat.kind == KIND_POP_BACK) begin
               cmd.cnt_op = CNT_DEC;
            end
            state_in = S_FINISH;
         end

         // linear search from the front
         S_FIND: begin
            priority if (stat.match) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
               cmd.take_found = 1'b1;
               state_in       = S_FINISH;
            end else if (stat.at_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end

         // one bubble pass: carry the smaller element to the pass end
         S_SORT_FIRST: begin
            cmd.carry_load = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_NEXT;
            state_in       = S_SORT_WALK;
         end

         S_SORT_WALK: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = WA_PREV;
            cmd.wr_data   = WD_MAX;
            cmd.carry_min = 1'b1;
            if (stat.at_lim) begin
               state_in = S_SORT_END;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end

         S_SORT_END: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_LIM;
            cmd.wr_data = WD_CARRY;
            if (stat.lim_is_one) begin
               state_in = S_FINISH;
            end else begin
               cmd.lim_dec = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_ZERO;
               state_in    = S_SORT_FIRST;
            end
         end

         // hand the result to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: src/positional_list_store_core.sv
// channel   | direction | handshake              | word fields
// ----------+-----------+------------------------+------------------------------------------
// request   | in        | req_valid / req_stall  | req_kind, req_position, req_value
// response  | out       | rsp_valid / rsp_stall  | rsp_status, rsp_data, rsp_found_at,
//           |           |                        | rsp_length, rsp_is_empty
//
// one request at a time; the single-port walk over the element store sets the time, with
// n the element count and p the 1-based slot: push back, clear, append at n+1, rejected
// requests and anything on an empty list need no walk; read and pop back read one element;
// insert and push front move slots p..n up; delete and pop front move slots p+1..n down;
// find stops at the first hit or at the end; sort runs bubble passes. reset clears the
// element count and the handshake, not the store. req_stall is high from acceptance until
// the response reaches the output register; a stalled response that holds that register delays it.
module positional_list_store_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pls_pkg::KIND_W-1:0]            req_kind,
   input  logic [pls_pkg::POS_W-1:0]             req_position,
   input  logic signed [pls_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pls_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [pls_pkg::DATA_WIDTH-1:0] rsp_data,
   output logic [pls_pkg::LEN_W-1:0]             rsp_found_at,
   output logic [pls_pkg::LEN_W-1:0]             rsp_length,
   output logic                                  rsp_is_empty
);
   import pls_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, count and result registers
   pls_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_found_at (rsp_found_at),
      .rsp_length   (rsp_length),
      .rsp_is_empty (rsp_is_empty)
   );

endmodule

// File: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pls_pkg::*;

   // generous cycle budget: ~620 words, a dozen full-length sorts, random stalls
   localparam int CYCLE_LIMIT = 1500000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_WORDS = 120;

   // one expected response word
   typedef struct {
      status_type                   status;
      logic signed [DATA_WIDTH-1:0] data;
      logic [LEN_W-1:0]             found_at;
      logic [LEN_W-1:0]             length;
      logic                         is_empty;
   } reply_t;

   // mirror of the list plus the replies still owed by the block
   class list_shadow;
      logic signed [DATA_WIDTH-1:0] elems [CAPACITY];
      int                           count;
      reply_t                       owed[$];
      int                           errors;
      int                           checked;
      int                           peak;
      int                           status_seen [8];

      function new();
         count = 0;
         errors = 0;
         checked = 0;
         peak = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
      endfunction

      // apply an accepted request to the mirror and queue its reply
      function void note_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_WIDTH-1:0] val);
         reply_t r;
         int n;
         int p;
         int k;
         int i;
         int j;
         logic signed [DATA_WIDTH-1:0] t;
         n = count;
         p = pos;
         r.status = ST_OK;
         r.data = '0;
         r.found_at = '0;
         case (kind)
            KIND_INSERT: begin
               if (p < 1 || p > n + 1) begin
                  r.status = ST_BAD_POS;
               end else if (n >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  for (k = n; k > p - 1; k--) elems[k] = elems[k-1];
                  elems[p-1] = val;
                  n++;
               end
            end
            KIND_DELETE, KIND_READ: begin
               if (n == 0) begin
                  r.status = ST_EMPTY;
               end else if (p < 1 || p > n) begin
                  r.status = ST_BAD_POS;
               end else begin
                  r.data = elems[p-1];
                  if (kind == KIND_DELETE) begin
                     for (k = p; k < n; k++) elems[k-1] = elems[k];
                     n--;
                  end
               end
            end
            KIND_FIND: begin
               r.status = ST_NOT_FOUND;
               for (k = 0; k < n; k++) begin
                  if (elems[k] == val) begin
                     r.found_at = LEN_W'(k + 1);
                     r.status = ST_OK;
                     break;
                  end
               end
            end
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
               if (n >= CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  if (kind == KIND_PUSH_FRONT) begin
                     for (k = n; k > 0; k--) elems[k] = elems[k-1];
                     elems[0] = val;
                  end else begin
                     elems[n] = val;
                  end
                  n++;
               end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
               if (n == 0) begin
                  r.status = ST_EMPTY;
               end else if (kind == KIND_POP_FRONT) begin
                  r.data = elems[0];
                  for (k = 1; k < n; k++) elems[k-1] = elems[k];
                  n--;
               end else begin
                  r.data = elems[n-1];
                  n--;
               end
            end
            KIND_CLEAR: n = 0;
            // descending signed order
            KIND_SORT: begin
               for (i = 0; i + 1 < n; i++) begin
                  for (j = 0; j + 1 < n - i; j++) begin
                     if (elems[j] < elems[j+1]) begin
                        t = elems[j];
                        elems[j] = elems[j+1];
                        elems[j+1] = t;
                     end
                  end
               end
            end
            default: ;
         endcase
         count = n;
         if (n > peak) peak = n;
         r.length = LEN_W'(n);
         r.is_empty = (n == 0);
         status_seen[r.status]++;
         owed.push_back(r);
      endfunction

      // compare a response word against the oldest owed reply
      function void check_response(input reply_t got);
         reply_t want;
         if (owed.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
            return;
         end
         want = owed.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("rsp_status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.data !== want.data) begin
            $error("rsp_data: expected %0d, got %0d", want.data, got.data);
            errors++;
         end
         if (got.found_at !== want.found_at) begin
            $error("rsp_found_at: expected %0d, got %0d", want.found_at, got.found_at);
            errors++;
         end
         if (got.length !== want.length) begin
            $error("rsp_length: expected %0d, got %0d", want.length, got.length);
            errors++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("rsp_is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [KIND_W-1:0]            req_kind = '0;
   logic [POS_W-1:0]             req_position = '0;
   logic signed [DATA_WIDTH-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [STATUS_W-1:0]          rsp_status;
   logic signed [DATA_WIDTH-1:0] rsp_data;
   logic [LEN_W-1:0]             rsp_found_at;
   logic [LEN_W-1:0]             rsp_length;
   logic                         rsp_is_empty;

   list_shadow shadow = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int cycles = 0;
   int words_sent = 0;

   // small pool so finds hit and duplicates occur
   logic signed [DATA_WIDTH-1:0] value_pool [8] = '{
      32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1, 32'sd5, 32'sd42, -32'sd7
   };

   positional_list_store_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_found_at (rsp_found_at),
      .rsp_length   (rsp_length),
      .rsp_is_empty (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: check accepted words, stall at random
   always @(posedge clock) begin
      reply_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = status_type'(rsp_status);
         got.data = rsp_data;
         got.found_at = rsp_found_at;
         got.length = rsp_length;
         got.is_empty = rsp_is_empty;
         shadow.check_response(got);
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // present one request word and hold it until accepted
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_WIDTH-1:0] val);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_position <= pos;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.note_request(kind, pos, val);
      words_sent++;
   endtask

   // hold off the sender until every owed reply has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.owed.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3 && shadow.count > 0) return shadow.elems[$urandom_range(0, shadow.count - 1)];
      if (r < 6) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // mostly legal slots, some just outside, a few anywhere
   function automatic logic [POS_W-1:0] pick_position(input bit for_insert);
      int top;
      int r;
      top = for_insert ? shadow.count + 1 : shadow.count;
      r = $urandom_range(0, 9);
      if (r < 8 && top > 0) return POS_W'($urandom_range(1, top));
      if (r < 9) return $urandom_range(0, 1) ? POS_W'(0) : POS_W'(top + 1);
      return POS_W'($urandom_range(0, 255));
   endfunction

   // weighted random mix with some noise words
   task automatic run_random(input int words);
      int r;
      for (int i = 0; i < words; i++) begin
         r = $urandom_range(0, 99);
         if (r < 16) send_request(KIND_INSERT, pick_position(1), pick_value());
         else if (r < 26) send_request(KIND_DELETE, pick_position(0), pick_value());
         else if (r < 38) send_request(KIND_READ, pick_position(0), pick_value());
         else if (r < 50) send_request(KIND_FIND, pick_position(0), pick_value());
         else if (r < 58) send_request(KIND_PUSH_FRONT, pick_position(0), pick_value());
         else if (r < 68) send_request(KIND_PUSH_BACK, pick_position(0), pick_value());
         else if (r < 75) send_request(KIND_POP_FRONT, pick_position(0), pick_value());
         else if (r < 82) send_request(KIND_POP_BACK, pick_position(0), pick_value());
         else if (r < 84) send_request(KIND_CLEAR, pick_position(0), pick_value());
         else if (r < 86) send_request(KIND_SORT, pick_position(0), pick_value());
         else if (r < 88)
            send_request(KIND_W'($urandom_range(10, 15)), POS_W'($urandom_range(0, 255)), $urandom);
         else
            send_request(KIND_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 255)), $urandom);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list cases
      send_request(KIND_READ, 8'd1, 32'sd0);
      send_request(KIND_DELETE, 8'd0, 32'sd0);
      send_request(KIND_POP_FRONT, 8'd0, 32'sd0);
      send_request(KIND_POP_BACK, 8'd0, 32'sd0);
      send_request(KIND_SORT, 8'd0, 32'sd0);
      send_request(KIND_FIND, 8'd0, 32'sd0);
      send_request(KIND_INSERT, 8'd0, 32'sd9);
      send_request(KIND_INSERT, 8'd2, 32'sd9);
      // directed: build a short list with extreme values
      send_request(KIND_INSERT, 8'd1, 32'sh7fffffff);
      send_request(KIND_PUSH_FRONT, 8'd0, 32'sh80000000);
      send_request(KIND_PUSH_BACK, 8'd0, -32'sd1);
      send_request(KIND_INSERT, 8'd4, 32'sd0);
      send_request(KIND_INSERT, 8'd2, -32'sd1);
      send_request(KIND_READ, 8'd255, 32'sd0);
      send_request(KIND_READ, 8'd6, 32'sd0);
      send_request(KIND_READ, 8'd5, 32'sd0);
      send_request(KIND_FIND, 8'd0, -32'sd1);
      send_request(KIND_FIND, 8'd0, 32'sd12345);
      send_request(KIND_SORT, 8'd0, 32'sd0);
      send_request(KIND_READ, 8'd1, 32'sd0);
      send_request(KIND_DELETE, 8'd3, 32'sd0);
      send_request(KIND_W'(10), 8'd3, 32'sd0);
      send_request(KIND_W'(15), 8'd255, -32'sd1);
      send_request(KIND_POP_FRONT, 8'd0, 32'sd0);
      send_request(KIND_POP_BACK, 8'd0, 32'sd0);
      send_request(KIND_CLEAR, 8'd0, 32'sd0);
      drain();

      // phase 1: no idling on either side
      idle_pct = 0;
      stall_pct = 0;
      run_random(PHASE_WORDS);
      drain();

      // phase 2: sender idles often
      idle_pct = 57;
      run_random(PHASE_WORDS);
      drain();

      // phase 3: fill to capacity, hit the full cases, then random near full
      idle_pct = 0;
      stall_pct = 57;
      while (shadow.count < CAPACITY) begin
         if ($urandom_range(0, 1)) send_request(KIND_PUSH_BACK, 8'd0, pick_value());
         else send_request(KIND_INSERT, POS_W'($urandom_range(1, shadow.count + 1)),
                           pick_value());
      end
      send_request(KIND_INSERT, 8'd1, 32'sd3);
      send_request(KIND_INSERT, 8'd129, 32'sd3);
      send_request(KIND_INSERT, 8'd130, 32'sd3);
      send_request(KIND_PUSH_FRONT, 8'd0, 32'sd3);
      send_request(KIND_PUSH_BACK, 8'd0, 32'sd3);
      send_request(KIND_SORT, 8'd0, 32'sd0);
      send_request(KIND_READ, 8'd128, 32'sd0);
      send_request(KIND_READ, 8'd129, 32'sd0);
      send_request(KIND_FIND, 8'd0, pick_value());
      send_request(KIND_DELETE, 8'd1, 32'sd0);
      send_request(KIND_PUSH_FRONT, 8'd0, 32'sh80000000);
      run_random(PHASE_WORDS);
      drain();

      // phase 4: both sides idle now and then
      idle_pct = 22;
      stall_pct = 22;
      run_random(PHASE_WORDS);
      drain();
      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d request words, %0d replies checked, %0d cycles",
               words_sent, shadow.checked, cycles);
      $display("list peaked at %0d entries; full %0d, empty %0d, bad slot %0d, miss %0d",
               shadow.peak, shadow.status_seen[ST_FULL], shadow.status_seen[ST_EMPTY],
               shadow.status_seen[ST_BAD_POS], shadow.status_seen[ST_NOT_FOUND]);
      if (shadow.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/pls_pkg.sv
src/pls_datapath.sv
src/pls_ctrl.sv
src/positional_list_store_core.sv
tb/sv/tb.sv
